// ===== hdl/dnc_pkg.sv =====
// Shared constants, operation codes and control structs for the decimal number classifier.
// No dependencies; compiled first.
package dnc_pkg;

  // Default width of the value that is classified.
  localparam int VALUE_BITS_DEF = 32;

  // Port field widths.
  localparam int OP_W      = 3;
  localparam int NUMBER_W  = 32;
  localparam int VERDICT_W = 2;
  localparam int VALUE_W   = 34;
  localparam int COUNT_W   = 4;
  localparam int SUM_W     = 7;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PARITY     = 3'd1;
  localparam logic [OP_W-1:0] OP_PRIME      = 3'd2;
  localparam logic [OP_W-1:0] OP_PALINDROME = 3'd3;
  localparam logic [OP_W-1:0] OP_SIGN       = 3'd4;
  localparam logic [OP_W-1:0] OP_REVERSE    = 3'd5;
  localparam logic [OP_W-1:0] OP_DIGIT_SUM  = 3'd6;

  // Verdict codes.
  localparam logic [VERDICT_W-1:0] VERDICT_YES  = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_NO   = 2'd1;
  localparam logic [VERDICT_W-1:0] SIGN_ZERO    = 2'd0;
  localparam logic [VERDICT_W-1:0] SIGN_NEG     = 2'd1;
  localparam logic [VERDICT_W-1:0] SIGN_POS     = 2'd2;

  // Divisor for decimal digit extraction.
  localparam int RADIX = 10;

  // Reciprocal of ten: for any 32-bit value x, x / 10 equals (x * RECIP10) >> RECIP10_SHIFT.
  localparam logic [31:0] RECIP10       = 32'hCCCCCCCD;
  localparam int          RECIP10_SHIFT = 35;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new transaction
    logic div_start;  // launch a pass of the trial divider or the divide-by-ten unit
    logic step;       // fold the divider result into the working registers
    logic emit;       // move the finished result into the output register
  } dnc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic finished;   // no more divider passes are needed
    logic div_done;   // divider result is available
  } dnc_status_t;

endpackage

// ===== hdl/dnc_if.sv =====
// Valid/ready channel interfaces for the classifier input and result streams.
// Depends on dnc_pkg.
interface dnc_in_if
  import dnc_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic        [OP_W-1:0]     operation;
  logic signed [NUMBER_W-1:0] number;

  modport source (output valid, output operation, output number, input ready);
  modport sink   (input valid, input operation, input number, output ready);
endinterface

interface dnc_out_if
  import dnc_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;
  logic [VALUE_W-1:0]   value_out;
  logic [COUNT_W-1:0]   digit_count;
  logic                 invalid_op;

  modport source (output valid, output verdict, output value_out, output digit_count,
                  output invalid_op, input ready);
  modport sink   (input valid, input verdict, input value_out, input digit_count,
                  input invalid_op, output ready);
endinterface

// ===== hdl/dnc_divider.sv =====
// Iterative restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; used by dnc_datapath.
module dnc_divider #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] remainder
);

  localparam int CW = (W > 1) ? $clog2(W) : 1;

  logic          busy;
  logic [CW-1:0] count;
  logic [W-1:0]  part;
  logic [W-1:0]  quot;
  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    shifted = {part, quot[W-1]};
    diff    = shifted - {1'b0, divisor};
    fits    = (shifted >= {1'b0, divisor});
  end

  // Control: busy while the quotient bits are produced, then a single-cycle done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      part <= '0;
      quot <= dividend;
    end else if (busy) begin
      part <= fits ? diff[W-1:0] : shifted[W-1:0];
      quot <= {quot[W-2:0], fits};
    end
  end

  assign remainder = part;

endmodule

// ===== hdl/dnc_datapath.sv =====
// Working registers, trial divider, divide-by-ten unit and result register of the classifier.
// Depends on dnc_pkg and dnc_divider; driven by dnc_controller commands.
module dnc_datapath
  import dnc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dnc_cmd_t             cmd,
  output dnc_status_t          status,
  input  logic [OP_W-1:0]      operation,
  input  logic [NUMBER_W-1:0]  number,
  output logic [VERDICT_W-1:0] verdict,
  output logic [VALUE_W-1:0]   value_out,
  output logic [COUNT_W-1:0]   digit_count,
  output logic                 invalid_op
);

  localparam int VB = VALUE_BITS;

  logic [OP_W-1:0]    op;
  logic [VB-1:0]      n;
  logic [VB-1:0]      t;
  logic [VB-1:0]      d;
  logic [VB-1:0]      sq;
  logic [VALUE_W-1:0] rev;
  logic [COUNT_W-1:0] cnt;
  logic [SUM_W-1:0]   sum;
  logic               composite;

  logic               in_pos;
  logic               n_neg;
  logic               n_zero;
  logic               n_lt2;
  logic               div_start;
  logic               div_done;
  logic [VB-1:0]      rem;
  logic [3:0]         digit;

  logic               d10_start;
  logic               d10_done;
  logic [63:0]        d10_prod;
  logic [3:0]         d10_low;
  logic [63-RECIP10_SHIFT:0] d10_q;
  logic [3:0]         d10_q10_low;
  logic [VB-1:0]      d10_quot;

  // Sign tests on the input value and on the captured value.
  always_comb begin
    in_pos = !number[VB-1] && (number[VB-1:0] != '0);
    n_neg  = n[VB-1];
    n_zero = (n == '0);
    n_lt2  = n_neg || (n[VB-1:1] == '0);
  end

  // Trial division runs on the restoring divider, digit extraction on the divide-by-ten unit.
  assign div_start = cmd.div_start && (op == OP_PRIME);
  assign d10_start = cmd.div_start && (op != OP_PRIME);

  dnc_divider #(.W(VB)) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (t),
    .divisor   (d),
    .done      (div_done),
    .remainder (rem)
  );

  // Divide by ten: the product with the reciprocal is registered and ready in the following cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      d10_done <= 1'b0;
    end else begin
      d10_done <= d10_start;
    end
  end

  always_ff @(posedge clk) begin
    if (d10_start) begin
      d10_prod <= {32'd0, 32'(t)} * {32'd0, RECIP10};
      d10_low  <= t[3:0];
    end
  end

  // The remainder is below ten, so the low four bits of t - 10q give the digit.
  always_comb begin
    d10_q       = d10_prod[63:RECIP10_SHIFT];
    d10_quot    = VB'(d10_q);
    d10_q10_low = {d10_q[0], 3'b000} + {d10_q[2:0], 1'b0};
    digit       = d10_low - d10_q10_low;
  end

  // Working registers: loaded per transaction, updated after each divider pass.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op        <= operation;
      n         <= number[VB-1:0];
      t         <= in_pos ? number[VB-1:0] : '0;
      d         <= VB'(2);
      sq        <= VB'(4);
      rev       <= '0;
      cnt       <= '0;
      sum       <= '0;
      composite <= 1'b0;
    end else if (cmd.step) begin
      if (op == OP_PRIME) begin
        if (rem == '0) begin
          composite <= 1'b1;
        end else begin
          d  <= d + 1'b1;
          sq <= sq + {d[VB-2:0], 1'b0} + 1'b1;
        end
      end else begin
        t   <= d10_quot;
        rev <= {rev[VALUE_W-4:0], 3'b000} + {rev[VALUE_W-2:0], 1'b0}
               + {{(VALUE_W-4){1'b0}}, digit};
        sum <= sum + {{(SUM_W-4){1'b0}}, digit};
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Tell the controller whether another divider pass is needed.
  always_comb begin
    status.div_done = (op == OP_PRIME) ? div_done : d10_done;
    case (op)
      OP_PRIME:                               status.finished = n_lt2 || composite || (sq > t);
      OP_PALINDROME, OP_REVERSE, OP_DIGIT_SUM: status.finished = (t == '0);
      default:                                status.finished = 1'b1;
    endcase
  end

  // Result register, loaded when the controller emits.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      verdict     <= '0;
      value_out   <= '0;
      digit_count <= '0;
      invalid_op  <= 1'b0;
      case (op)
        OP_PARITY: begin
          verdict <= {1'b0, n[0]};
        end
        OP_PRIME: begin
          verdict <= (n_lt2 || composite) ? VERDICT_NO : VERDICT_YES;
        end
        OP_PALINDROME: begin
          verdict <= (!n_neg && (rev == VALUE_W'(n))) ? VERDICT_YES : VERDICT_NO;
        end
        OP_SIGN: begin
          verdict <= n_zero ? SIGN_ZERO : (n_neg ? SIGN_NEG : SIGN_POS);
        end
        OP_REVERSE: begin
          value_out   <= rev;
          digit_count <= cnt;
        end
        OP_DIGIT_SUM: begin
          value_out <= VALUE_W'(sum);
        end
        default: begin
          invalid_op <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== hdl/dnc_controller.sv =====
// Sequencing state machine and handshake control for the classifier.
// Depends on dnc_pkg; drives dnc_datapath through command and status structs.
module dnc_controller
  import dnc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  dnc_status_t status,
  output dnc_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_CLASSIFY = 4'b0010,
    S_DIV      = 4'b0100,
    S_FINISH   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Next state and commands.
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.load      = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        if (status.finished) begin
          state_next = S_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          cmd.step   = 1'b1;
          state_next = S_CLASSIFY;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output valid: set on emit, cleared when the result transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== hdl/decimal_number_classifier.sv =====
// Channel      Direction  Payload
// in_ch        sink       operation[2:0], number[31:0] signed
// out_ch       source     verdict[1:0], value_out[33:0], digit_count[3:0], invalid_op
//
// Parity, sign and invalid codes pass from input through the classify and finish steps
// to the result register. Digit operations take one divider pass per decimal digit on the
// registered multiply by the reciprocal of ten; primality takes one pass per trial
// divisor on the bit-serial divider, up to the square root of the value.
// One transaction is in work at a time.
// A finished result waits in the output register while the next input is accepted;
// a stalled result only holds the sequencer at its final step. Reset is synchronous.
// Depends on dnc_pkg, dnc_if, dnc_controller and dnc_datapath.
module decimal_number_classifier
  import dnc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  dnc_in_if.sink    in_ch,
  dnc_out_if.source out_ch
);

  dnc_cmd_t    cmd;
  dnc_status_t status;

  dnc_controller u_controller (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  dnc_datapath #(.VALUE_BITS(VALUE_BITS)) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .operation   (in_ch.operation),
    .number      (in_ch.number),
    .verdict     (out_ch.verdict),
    .value_out   (out_ch.value_out),
    .digit_count (out_ch.digit_count),
    .invalid_op  (out_ch.invalid_op)
  );

endmodule
